[src/lasb_pkg.sv]
// shared constants and types for the layered alpha to sequential blend unit
package lasb_pkg;

    localparam int unsigned NUM_LAYERS  = 3;
    localparam int unsigned SHARE_W     = 8;
    localparam int unsigned CNT_W       = 3;
    localparam int unsigned NUM_W       = 17;
    localparam int unsigned DEN_W       = 9;
    localparam int unsigned Q_W         = 8;
    localparam int unsigned BITS_PER_ST = 2;
    localparam int unsigned STEP_STAGES = Q_W / BITS_PER_ST;
    localparam int unsigned DIV_STAGES  = 1 + STEP_STAGES;
    localparam int unsigned PIPE_DEPTH  = 2 + DIV_STAGES;

    localparam logic [CNT_W-1:0]   CNT_RESET = 3'd4;
    localparam logic [CNT_W-1:0]   CNT_MAX   = 3'd4;
    localparam logic [CNT_W-1:0]   CNT_MIN   = 3'd2;
    localparam logic [SHARE_W-1:0] FULL_VIS  = 8'd255;
    localparam logic [NUM_W-1:0]   NUM_SCALE = 17'd510;

    typedef logic [SHARE_W-1:0] share_t;

    typedef struct packed {
        logic             en;
        logic             sat;
        logic [NUM_W-1:0] r;
        logic [DEN_W-1:0] den;
        logic [Q_W-1:0]   q;
    } div_lane_t;

    // one restoring step of the weight divider at quotient bit b
    function automatic div_lane_t div_step(input div_lane_t l, input logic [2:0] b);
        div_lane_t        o;
        logic [NUM_W-1:0] d;
        o = l;
        d = NUM_W'(l.den) << b;
        if (l.r >= d) begin
            o.r    = l.r - d;
            o.q[b] = 1'b1;
        end
        return o;
    endfunction

endpackage

[src/layered_alpha_to_sequential_blend_unit.sv]
// layered alpha shares to sequential blend weights, pipelined
// path: an accepted input word runs through the share, numerator, overflow and divider stages to m_valid
// throughput: one word per cycle unless m_ready stalls the output, set by the 8-bit restoring
//   weight divider that retires two quotient bits per stage in three parallel lanes
// reset: aresetn low clears every stage valid bit and sets layer_count to 4
module layered_alpha_to_sequential_blend_unit
    import lasb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [SHARE_W-1:0] s_layer1_share,
    input  logic [SHARE_W-1:0] s_layer2_share,
    input  logic [SHARE_W-1:0] s_layer3_share,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [Q_W-1:0]     m_layer1_blend,
    output logic [Q_W-1:0]     m_layer2_blend,
    output logic [Q_W-1:0]     m_layer3_blend,
    output logic               m_saturated
);

    logic [CNT_W-1:0]      layer_count_reg;
    logic [PIPE_DEPTH-1:0] vld_reg;
    logic [PIPE_DEPTH-1:0] stage_en;

    share_t                s_share [NUM_LAYERS];
    logic [1:0]            used;
    logic [NUM_LAYERS-1:0] act;
    logic signed [10:0]    rem [NUM_LAYERS];

    share_t                sh_reg     [NUM_LAYERS];
    share_t                sh_next    [NUM_LAYERS];
    share_t                rem_reg    [NUM_LAYERS];
    share_t                rem_next   [NUM_LAYERS];
    logic [NUM_LAYERS-1:0] gate_reg;
    logic [NUM_LAYERS-1:0] gate_next;

    logic [NUM_W-1:0]      num_reg    [NUM_LAYERS];
    logic [NUM_W-1:0]      num_next   [NUM_LAYERS];
    logic [DEN_W-1:0]      den_reg    [NUM_LAYERS];
    logic [DEN_W-1:0]      den_next   [NUM_LAYERS];
    logic [NUM_LAYERS-1:0] gate2_reg;

    div_lane_t             dv_reg  [DIV_STAGES][NUM_LAYERS];
    div_lane_t             dv_next [DIV_STAGES][NUM_LAYERS];

    logic [Q_W-1:0]        blend [NUM_LAYERS];
    logic [NUM_LAYERS-1:0] sat_any;

    // stall chain, bubbles collapse
    always_comb begin
        stage_en[PIPE_DEPTH-1] = !vld_reg[PIPE_DEPTH-1] || m_ready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--) begin
            stage_en[i] = !vld_reg[i] || stage_en[i+1];
        end
    end

    assign s_ready = stage_en[0];
    assign m_valid = vld_reg[PIPE_DEPTH-1];

    // remaining visibility in front of each layer, top layer first
    always_comb begin
        s_share[0] = s_layer1_share;
        s_share[1] = s_layer2_share;
        s_share[2] = s_layer3_share;
        if (layer_count_reg > CNT_MAX) begin
            used = 2'(CNT_MAX - 3'd1);
        end else if (layer_count_reg >= CNT_MIN) begin
            used = 2'(layer_count_reg - 3'd1);
        end else begin
            used = 2'd0;
        end
        for (int k = 0; k < NUM_LAYERS; k++) begin
            act[k] = used > 2'(k);
        end
        rem[2] = 11'(FULL_VIS);
        rem[1] = rem[2] - (act[2] ? $signed(11'(s_share[2])) : 11'sd0);
        rem[0] = rem[1] - (act[1] ? $signed(11'(s_share[1])) : 11'sd0);
        for (int k = 0; k < NUM_LAYERS; k++) begin
            sh_next[k]   = s_share[k];
            rem_next[k]  = rem[k][SHARE_W-1:0];
            gate_next[k] = act[k] && (rem[k] > 11'sd0);
        end
    end

    // numerator and divisor of the rounded quotient
    always_comb begin
        for (int k = 0; k < NUM_LAYERS; k++) begin
            num_next[k] = NUM_W'(sh_reg[k]) * NUM_SCALE + NUM_W'(rem_reg[k]);
            den_next[k] = {rem_reg[k], 1'b0};
        end
    end

    // overflow check, then two quotient bits per stage
    always_comb begin
        for (int k = 0; k < NUM_LAYERS; k++) begin
            dv_next[0][k].en  = gate2_reg[k];
            dv_next[0][k].sat = num_reg[k] >= {den_reg[k], 8'b0};
            dv_next[0][k].r   = num_reg[k];
            dv_next[0][k].den = den_reg[k];
            dv_next[0][k].q   = '0;
        end
        for (int j = 1; j < DIV_STAGES; j++) begin
            for (int k = 0; k < NUM_LAYERS; k++) begin
                dv_next[j][k] = div_step(
                    div_step(dv_reg[j-1][k], 3'(Q_W - 1 - BITS_PER_ST * (j - 1))),
                    3'(Q_W - 2 - BITS_PER_ST * (j - 1)));
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            layer_count_reg <= CNT_RESET;
            vld_reg         <= '0;
        end else begin
            if (cfg_we) begin
                layer_count_reg <= cfg_wdata;
            end
            if (stage_en[0]) begin
                vld_reg[0] <= s_valid;
            end
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                if (stage_en[i]) begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (stage_en[0]) begin
            sh_reg   <= sh_next;
            rem_reg  <= rem_next;
            gate_reg <= gate_next;
        end
        if (stage_en[1]) begin
            num_reg   <= num_next;
            den_reg   <= den_next;
            gate2_reg <= gate_reg;
        end
        for (int j = 0; j < DIV_STAGES; j++) begin
            if (stage_en[2+j]) begin
                dv_reg[j] <= dv_next[j];
            end
        end
    end

    // clip and gate the result word
    always_comb begin
        for (int k = 0; k < NUM_LAYERS; k++) begin
            if (!dv_reg[DIV_STAGES-1][k].en) begin
                blend[k] = '0;
            end else if (dv_reg[DIV_STAGES-1][k].sat) begin
                blend[k] = '1;
            end else begin
                blend[k] = dv_reg[DIV_STAGES-1][k].q;
            end
            sat_any[k] = dv_reg[DIV_STAGES-1][k].en && dv_reg[DIV_STAGES-1][k].sat;
        end
    end

    assign m_layer1_blend = blend[0];
    assign m_layer2_blend = blend[1];
    assign m_layer3_blend = blend[2];
    assign m_saturated    = |sat_any;

`ifndef SYNTHESIS
    a_sat_clips: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_saturated |->
            (m_layer1_blend == 8'hFF || m_layer2_blend == 8'hFF || m_layer3_blend == 8'hFF))
        else $error("saturated word without a clipped weight");

    a_full_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (m_valid && !m_ready && (&vld_reg)))
        else $error("input stalled while the pipeline has room");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && !vld_reg[PIPE_DEPTH-2] |=> !m_valid)
        else $error("result word repeated after it was taken");
`endif

endmodule

[sim/blend_weight_checker.sv]
// checker that predicts blend weights per accepted word and compares the result words
`timescale 1ns / 100ps

module blend_weight_checker
    import lasb_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [CNT_W-1:0]   cfg_wdata,
    input  logic               s_valid,
    input  logic               s_ready,
    input  logic [SHARE_W-1:0] s_layer1_share,
    input  logic [SHARE_W-1:0] s_layer2_share,
    input  logic [SHARE_W-1:0] s_layer3_share,
    input  logic               m_valid,
    input  logic               m_ready,
    input  logic [Q_W-1:0]     m_layer1_blend,
    input  logic [Q_W-1:0]     m_layer2_blend,
    input  logic [Q_W-1:0]     m_layer3_blend,
    input  logic               m_saturated,
    output int                 mismatch_count,
    output int                 words_in_flight
);

    typedef struct packed {
        logic [Q_W-1:0] blend1;
        logic [Q_W-1:0] blend2;
        logic [Q_W-1:0] blend3;
        logic           sat;
    } blend_word_t;

    blend_word_t      expected_blends[$];
    logic [CNT_W-1:0] layer_count;
    int               mismatch_total = 0;

    function automatic blend_word_t predict_blend_weights(input share_t s1, input share_t s2,
                                                         input share_t s3,
                                                         input logic [CNT_W-1:0] count);
        blend_word_t w;
        int          share_of[3];
        int          weight[3];
        int          remain;
        int          alpha_used;
        share_of[0] = int'(s1);
        share_of[1] = int'(s2);
        share_of[2] = int'(s3);
        weight      = '{0, 0, 0};
        remain      = int'(FULL_VIS);
        w.sat       = 1'b0;
        alpha_used  = (count > CNT_MAX) ? int'(CNT_MAX) : int'(count);
        alpha_used  = (alpha_used >= int'(CNT_MIN)) ? alpha_used - 1 : 0;
        // top layer first, remaining visibility shrinks by each share
        for (int k = alpha_used - 1; k >= 0; k--) begin
            if (remain > 0) begin
                weight[k] = (2 * share_of[k] * int'(FULL_VIS) + remain) / (2 * remain);
                if (weight[k] > int'(FULL_VIS)) begin
                    weight[k] = int'(FULL_VIS);
                    w.sat     = 1'b1;
                end
                remain -= share_of[k];
            end
        end
        w.blend1 = Q_W'(weight[0]);
        w.blend2 = Q_W'(weight[1]);
        w.blend3 = Q_W'(weight[2]);
        return w;
    endfunction

    task automatic check_field(input string field, input logic [Q_W-1:0] want,
                               input logic [Q_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, actual %0d", field, want, got);
            mismatch_total++;
        end
    endtask

    always @(posedge aclk) begin
        blend_word_t want;
        blend_word_t predicted;
        if (!aresetn) begin
            expected_blends.delete();
            layer_count = CNT_RESET;
        end else begin
            if (s_valid && s_ready) begin
                predicted = predict_blend_weights(s_layer1_share, s_layer2_share,
                                                  s_layer3_share, layer_count);
                expected_blends = {expected_blends, predicted};
            end
            if (cfg_we)
                layer_count = cfg_wdata;
            if (m_valid && m_ready) begin
                if (expected_blends.size() == 0) begin
                    $error("result word with no expectation waiting");
                    mismatch_total++;
                end else begin
                    want = expected_blends.pop_front();
                    check_field("layer1_blend", want.blend1, m_layer1_blend);
                    check_field("layer2_blend", want.blend2, m_layer2_blend);
                    check_field("layer3_blend", want.blend3, m_layer3_blend);
                    check_field("saturated", Q_W'(want.sat), Q_W'(m_saturated));
                end
            end
        end
        words_in_flight <= expected_blends.size();
        mismatch_count  <= mismatch_total;
    end

endmodule

[sim/tb_top.sv]
// top of the blend unit testbench: clock, reset, stimulus, result stalls and verdict
`timescale 1ns / 100ps

module tb_top
    import lasb_pkg::*;
;

    localparam int QUIET_LIMIT  = 2000;
    localparam int PHASE_WORDS  = 140;
    localparam int HOLD_CYCLES  = 300;
    localparam int NUM_PHASES   = 9;

    logic               aclk           = 1'b0;
    logic               aresetn        = 1'b0;
    logic               cfg_we         = 1'b0;
    logic [CNT_W-1:0]   cfg_wdata      = CNT_RESET;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [SHARE_W-1:0] s_layer1_share = '0;
    logic [SHARE_W-1:0] s_layer2_share = '0;
    logic [SHARE_W-1:0] s_layer3_share = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [Q_W-1:0]     m_layer1_blend;
    logic [Q_W-1:0]     m_layer2_blend;
    logic [Q_W-1:0]     m_layer3_blend;
    logic               m_saturated;

    int   mismatches;
    int   results_owed;
    int   quiet_cycles   = 0;
    logic hold_requested = 1'b0;

    logic [CNT_W-1:0] phase_counts[NUM_PHASES] = '{3'd4, 3'd3, 3'd0, 3'd7, 3'd2,
                                                  3'd1, 3'd5, 3'd6, 3'd4};

    // {layer1, layer2, layer3}
    logic [23:0] directed_words[19] = '{
        {8'd0,   8'd0,   8'd0},
        {8'd255, 8'd255, 8'd255},
        {8'd255, 8'd0,   8'd0},
        {8'd0,   8'd255, 8'd0},
        {8'd0,   8'd0,   8'd255},
        {8'd0,   8'd127, 8'd1},
        {8'd0,   8'd100, 8'd200},
        {8'd50,  8'd100, 8'd200},
        {8'd100, 8'd0,   8'd255},
        {8'd1,   8'd1,   8'd1},
        {8'hAA,  8'h55,  8'hAA},
        {8'h55,  8'hAA,  8'h55},
        {8'd85,  8'd85,  8'd85},
        {8'd86,  8'd85,  8'd85},
        {8'd0,   8'd0,   8'd1},
        {8'd254, 8'd0,   8'd1},
        {8'd10,  8'd20,  8'd30},
        {8'd128, 8'd64,  8'd32},
        {8'd127, 8'd128, 8'd0}
    };

    layered_alpha_to_sequential_blend_unit dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_layer1_share (s_layer1_share),
        .s_layer2_share (s_layer2_share),
        .s_layer3_share (s_layer3_share),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_layer1_blend (m_layer1_blend),
        .m_layer2_blend (m_layer2_blend),
        .m_layer3_blend (m_layer3_blend),
        .m_saturated    (m_saturated)
    );

    blend_weight_checker checker_i (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_layer1_share  (s_layer1_share),
        .s_layer2_share  (s_layer2_share),
        .s_layer3_share  (s_layer3_share),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_layer1_blend  (m_layer1_blend),
        .m_layer2_blend  (m_layer2_blend),
        .m_layer3_blend  (m_layer3_blend),
        .m_saturated     (m_saturated),
        .mismatch_count  (mismatches),
        .words_in_flight (results_owed)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_word(input logic [7:0] l1, input logic [7:0] l2, input logic [7:0] l3,
                             input int gap);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_layer1_share <= l1;
        s_layer2_share <= l2;
        s_layer3_share <= l3;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic drain_words();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_owed != 0);
    endtask

    task automatic write_layer_count(input logic [CNT_W-1:0] count);
        cfg_we    <= 1'b1;
        cfg_wdata <= count;
        @(posedge aclk);
        cfg_we    <= 1'b0;
    endtask

    // half layered shares that fit in full visibility, a fifth on the edge, rest uniform
    task automatic make_shares(output logic [7:0] l1, output logic [7:0] l2,
                               output logic [7:0] l3);
        int pick;
        pick = $urandom_range(0, 9);
        if (pick < 5) begin
            l3 = 8'($urandom_range(0, 255));
            l2 = 8'($urandom_range(0, 255 - l3));
            l1 = 8'($urandom_range(0, 255 - l3 - l2));
        end else if (pick < 7) begin
            l3 = 8'($urandom_range(0, 255));
            l2 = 8'($urandom_range(0, 255 - l3));
            l1 = 8'(255 - l3 - l2 + $urandom_range(0, 1));
        end else begin
            l1 = 8'($urandom_range(0, 255));
            l2 = 8'($urandom_range(0, 255));
            l3 = 8'($urandom_range(0, 255));
        end
    endtask

    initial begin
        logic [7:0] l1;
        logic [7:0] l2;
        logic [7:0] l3;
        int         gap;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        foreach (directed_words[i])
            send_word(directed_words[i][23:16], directed_words[i][15:8],
                      directed_words[i][7:0], $urandom_range(0, 14));
        for (int phase = 0; phase < NUM_PHASES; phase++) begin
            drain_words();
            write_layer_count(phase_counts[phase]);
            if (phase == 3)
                hold_requested = 1'b1;
            for (int n = 0; n < PHASE_WORDS; n++) begin
                make_shares(l1, l2, l3);
                gap = (phase % 2 == 0) ? $urandom_range(0, 14) : 0;
                send_word(l1, l2, l3, gap);
            end
        end
        drain_words();
        repeat (4 * PIPE_DEPTH) @(posedge aclk);
        if (mismatches == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

    initial begin
        int stall;
        int taken;
        taken = 0;
        wait (aresetn);
        forever begin
            // every third stretch of 80 words goes without stalls
            stall = ((taken / 80) % 3 == 2) ? 0 : $urandom_range(0, 14);
            if (hold_requested) begin
                hold_requested = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            taken++;
        end
    end

endmodule

[sim.f]
src/lasb_pkg.sv
src/layered_alpha_to_sequential_blend_unit.sv
sim/blend_weight_checker.sv
sim/tb_top.sv
